// ===== hw/rtl/polynomial_atan2_assert.svh =====
// Assertion macros for the polynomial arctangent block.
`ifndef POLYNOMIAL_ATAN2_ASSERT_SVH
`define POLYNOMIAL_ATAN2_ASSERT_SVH
`ifndef ASSERT_OFF
`define PA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define PA_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) (!rstn) |-> (prop)) else $error("%m failed in reset");
`else
`define PA_ASSERT(lbl, clk, rstn, prop)
`define PA_ASSERT_RST(lbl, clk, rstn, prop)
`endif
`endif

// ===== hw/rtl/pa_pkg.sv =====
// Shared constants and types of the polynomial arctangent block.
package pa_pkg;
  localparam int QS = 30;
  localparam logic signed [31:0] COEF_C0 = -32'sd14474544;
  localparam logic signed [31:0] COEF_C1 = 32'sd61715796;
  localparam logic signed [31:0] COEF_C2 = -32'sd130179461;
  localparam logic signed [31:0] COEF_C3 = 32'sd210062475;
  localparam logic signed [31:0] COEF_C4 = -32'sd357550226;
  localparam logic signed [31:0] COEF_C5 = 32'sd1073737132;
  localparam logic signed [33:0] HALF_PI_Q = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q = 34'sd3373259427;

  // Flags carried alongside each request through the pipeline.
  typedef struct packed {
    logic zero;
    logic swap;
    logic x_neg;
    logic y_neg;
  } flags_t;

  // Q2.30 product rounded to nearest, ties away from zero.
  function automatic logic signed [31:0] qmul(logic signed [31:0] a,
                                              logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] s;
    p = 64'(a) * 64'(b);
    m = p[63] ? (64'd0 - 64'(p)) : 64'(p);
    s = (m + (64'd1 << (QS - 1))) >> QS;
    return p[63] ? (32'd0 - s[31:0]) : s[31:0];
  endfunction
endpackage

// ===== hw/rtl/polynomial_atan2.sv =====
// Top level of the pipelined four-quadrant polynomial arctangent.
//  channel  dir  payload
//  s_axis   in   tdata = {x_coord, y_coord}
//  m_axis   out  tdata = angle
// One request enters per cycle while m_axis is not stalled; the pipeline has 1 front,
// 31 divider and 9 Horner and reflection stages. The divider stages set the depth.
// Reset clears all valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
`include "polynomial_atan2_assert.svh"
module polynomial_atan2 #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // y_coord [CW-1:0], x_coord [2CW-1:CW]
  input  logic [2*COORD_WIDTH-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // angle [AW-1:0]
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int OW = ((AW + 7) / 8) * 8;

  logic en;
  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  logic signed [CW-1:0] y, x;
  logic [CW:0] ay, ax;
  assign y = s_axis_tdata[CW-1:0];
  assign x = s_axis_tdata[2*CW-1:CW];
  assign ay = y[CW-1] ? ((CW+1)'(0) - (CW+1)'(y)) : (CW+1)'(y);
  assign ax = x[CW-1] ? ((CW+1)'(0) - (CW+1)'(x)) : (CW+1)'(x);

  logic v_q;
  logic [CW:0] lo_q, hi_q;
  pa_pkg::flags_t fl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hi_q <= (ay > ax) ? ay : ax;
      lo_q <= (ay > ax) ? ax : ay;
      fl_q.swap  <= ay > ax;
      fl_q.x_neg <= x[CW-1];
      fl_q.y_neg <= y[CW-1];
      fl_q.zero  <= (ay == '0) && (ax == '0);
    end
  end

  logic dv;
  logic [31:0] ratio;
  pa_pkg::flags_t dfl;
  logic [CW:0] hi_safe;
  assign hi_safe = (hi_q == '0) ? (CW+1)'(1) : hi_q;
  pa_divider #(.CW(CW+1)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q), .lo_i(lo_q), .hi_i(hi_safe),
    .flags_i(fl_q), .valid_o(dv), .ratio_o(ratio), .flags_o(dfl)
  );

  logic [AW-1:0] angle;
  pa_horner #(.AW(AW)) u_hor (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .ratio_i(ratio), .flags_i(dfl),
    .valid_o(m_axis_tvalid), .angle_o(angle)
  );
  assign m_axis_tdata = OW'(angle);

  `PA_ASSERT(a_ready_eq, clk_i, rst_ni, s_axis_tready == (m_axis_tready || !m_axis_tvalid))
  `PA_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `PA_ASSERT_RST(a_rst, clk_i, rst_ni, ##1 1'b1)
endmodule

// ===== hw/rtl/pa_divider.sv =====
// Pipelined restoring divider forming the Q2.30 ratio lo/hi, one quotient bit per stage.
module pa_divider #(
  parameter int CW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [CW-1:0] lo_i,
  input  logic [CW-1:0] hi_i,
  input  pa_pkg::flags_t flags_i,
  output logic          valid_o,
  output logic [31:0]   ratio_o,
  output pa_pkg::flags_t flags_o
);
  localparam int NS = 31;
  localparam int RW = CW + 1;

  // Stage s settles quotient bit 30-s; register set s holds its result.
  logic [NS-1:0]          v_q;
  logic [RW-1:0]          rem_q [NS];
  logic [CW-1:0]          den_q [NS];
  logic [30:0]            quo_q [NS];
  pa_pkg::flags_t         fl_q  [NS];

  logic [RW-1:0]          rem_d [NS];
  logic [CW-1:0]          den_d [NS];
  logic [30:0]            quo_d [NS];

  // The numerator is lo*2^30 + hi/2. The first stage takes lo together with the one bit
  // of hi/2 that can reach the integer position; each later stage brings down one bit of hi/2.
  always_comb begin
    int pv;
    logic [63:0] den_w;
    logic [RW:0] sh;
    logic [RW:0] df;
    logic [30:0] quo;
    logic [CW-1:0] den;
    for (int s = 0; s < NS; s++) begin
      pv = (s == 0) ? 0 : s - 1;
      if (s == 0) begin
        den = hi_i;
        quo = '0;
      end else begin
        den = den_q[pv];
        quo = quo_q[pv];
      end
      den_w = 64'(den);
      sh = (s == 0) ? ((RW+1)'(lo_i) + (RW+1)'(den_w[31])) : {rem_q[pv], den_w[31-s]};
      df = sh - (RW+1)'(den);
      den_d[s] = den;
      quo_d[s] = {quo[29:0], ~df[RW]};
      rem_d[s] = df[RW] ? sh[RW-1:0] : df[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_d[s];
        quo_q[s] <= quo_d[s];
        fl_q[s]  <= (s == 0) ? flags_i : fl_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  logic unused;
  assign unused = ^{rem_q[NS-1], den_q[NS-1]};
  assign valid_o = v_q[NS-1];
  assign ratio_o = {1'b0, quo_q[NS-1]};
  assign flags_o = fl_q[NS-1];
endmodule

// ===== hw/rtl/pa_horner.sv =====
// Horner evaluation of the odd polynomial and the quadrant reflection, at most one multiply per stage.
module pa_horner #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   ratio_i,
  input  pa_pkg::flags_t flags_i,
  output logic          valid_o,
  output logic [AW-1:0] angle_o
);
  localparam int NS = 9;
  localparam int SH = pa_pkg::QS - (AW - 3);

  logic [NS-1:0]            v_q;
  logic signed [31:0]       r_q   [NS];
  logic signed [31:0]       r2_q  [NS];
  logic signed [31:0]       acc_q [NS];
  pa_pkg::flags_t           fl_q  [NS];

  logic signed [31:0] stage_d [NS];
  logic signed [33:0] a0, a1, a2, a3;
  logic [33:0] am;
  logic [33:0] ar;

  always_comb begin
    stage_d[0] = pa_pkg::qmul(ratio_i, ratio_i);
    stage_d[1] = pa_pkg::qmul(pa_pkg::COEF_C0, r2_q[0]) + pa_pkg::COEF_C1;
    stage_d[2] = pa_pkg::qmul(acc_q[1], r2_q[1]) + pa_pkg::COEF_C2;
    stage_d[3] = pa_pkg::qmul(acc_q[2], r2_q[2]) + pa_pkg::COEF_C3;
    stage_d[4] = pa_pkg::qmul(acc_q[3], r2_q[3]) + pa_pkg::COEF_C4;
    stage_d[5] = pa_pkg::qmul(acc_q[4], r2_q[4]) + pa_pkg::COEF_C5;
    stage_d[6] = pa_pkg::qmul(acc_q[5], r_q[5]);
    a0 = 34'(acc_q[6]);
    a1 = fl_q[6].swap ? (pa_pkg::HALF_PI_Q - a0) : a0;
    a2 = fl_q[6].x_neg ? (pa_pkg::PI_Q - a1) : a1;
    a3 = fl_q[6].y_neg ? -a2 : a2;
    stage_d[7] = 32'(a3 >>> 2);
    am = a3[33] ? (34'd0 - 34'(a3)) : 34'(a3);
    stage_d[8] = '0;
    ar = ({2'b00, acc_q[8]} + (34'd1 << (SH - 1))) >> SH;
  end

  // Stage seven keeps the angle split as an unsigned Q2.30 magnitude and a sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= ratio_i;
      r2_q[0] <= stage_d[0];
      acc_q[0] <= '0;
      fl_q[0] <= flags_i;
      for (int s = 1; s < NS; s++) begin
        r_q[s]  <= r_q[s-1];
        r2_q[s] <= r2_q[s-1];
      end
      for (int s = 1; s < 7; s++) begin
        fl_q[s] <= fl_q[s-1];
      end
      fl_q[7] <= '{zero: fl_q[6].zero, swap: fl_q[6].swap, x_neg: fl_q[6].x_neg,
                   y_neg: a3[33]};
      fl_q[8] <= fl_q[7];
      for (int s = 1; s < 7; s++) begin
        acc_q[s] <= stage_d[s];
      end
      acc_q[7] <= 32'(am);
      acc_q[8] <= acc_q[7];
    end
  end

  logic [AW-1:0] mag;
  assign mag = AW'(ar);
  assign valid_o = v_q[NS-1];
  assign angle_o = fl_q[8].zero ? '0 : (fl_q[8].y_neg ? (AW'(0) - mag) : mag);
  logic unused;
  assign unused = ^{stage_d[7], stage_d[8], acc_q[0], r2_q[NS-1], r_q[NS-1]};
endmodule
